@@ src/gott_pkg.sv @@
package gott_pkg;

  localparam int unsigned TableDepth = 16;
  localparam int unsigned SlotW      = $clog2(TableDepth);
  localparam int unsigned CountW     = $clog2(TableDepth + 1);

  localparam int unsigned IdW    = 16;
  localparam int unsigned PosW   = 12;
  localparam int unsigned AreaW  = 20;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned GateW  = 8;
  localparam int unsigned PeriodW = 16;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned RemW   = 9;

  localparam logic [1:0] RegGate    = 2'd0;
  localparam logic [1:0] RegTimeout = 2'd1;
  localparam logic [1:0] RegPeriod  = 2'd2;

  localparam logic [1:0] StMatched = 2'd0;
  localparam logic [1:0] StCreated = 2'd1;
  localparam logic [1:0] StFull    = 2'd2;
  localparam logic [1:0] StSweep   = 2'd3;

  // Command carried down the chain, one cell per cycle.
  typedef struct packed {
    logic               valid;
    logic               sweep;
    logic               renew;
    logic [PosW-1:0]    pos_x;
    logic [PosW-1:0]    pos_y;
    logic [AreaW-1:0]   area;
    logic [AreaW-1:0]   box_area;
    logic [TimeW-1:0]   now_ms;
    logic               done;
    logic               matched;
    logic [IdW-1:0]     id;
    logic [CountW-1:0]  removed;
  } gott_tok_t;

  typedef struct packed {
    logic [GateW-1:0]   gate_radius;
    logic [PeriodW-1:0] lost_timeout_ms;
    logic [PeriodW-1:0] new_period_ms;
  } gott_cfg_t;

endpackage

@@ src/gott_cell.sv @@
module gott_cell import gott_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  gott_cfg_t   cfg_i,
  input  logic        alloc_i,
  input  logic [IdW-1:0] alloc_id_i,
  input  gott_tok_t   alloc_tok_i,
  input  gott_tok_t   tok_i,
  output gott_tok_t   tok_o,
  output logic        valid_o
);

  logic              valid_q, valid_d;
  logic              new_q, new_d;
  logic [IdW-1:0]    id_q, id_d;
  logic [PosW-1:0]   x_q, x_d, y_q, y_d;
  logic [AreaW-1:0]  size_q, size_d;
  logic [TimeW-1:0]  seen_q, seen_d, renewed_q, renewed_d;
  gott_tok_t         tok_q, tok_d;

  logic [GateW+1:0]  half;
  logic              in_win, size_ok, wide, hit, do_tok;
  logic [TimeW-1:0]  age_new, age_seen;
  logic [AreaW+2:0]  a5, s5, a4, s4;

  function automatic logic win(input logic [PosW-1:0] c, input logic [PosW-1:0] p,
                               input logic [GateW+1:0] h);
    logic [PosW+2:0] cc, pp, hh;
    begin
      cc = {3'b000, c}; pp = {3'b000, p}; hh = {{(PosW-GateW+1){1'b0}}, h};
      win = (cc < pp + hh) && (cc + hh > pp);
    end
  endfunction

  always_comb begin
    wide     = tok_i.renew || new_q;
    half     = wide ? {1'b0, cfg_i.gate_radius, 1'b0} : {2'b00, cfg_i.gate_radius};
    in_win   = win(x_q, tok_i.pos_x, half) && win(y_q, tok_i.pos_y, half);
    a5 = ({3'b000, tok_i.area} << 2) + {3'b000, tok_i.area};
    a4 = {3'b000, tok_i.area} << 2;
    s5 = ({3'b000, size_q} << 2) + {3'b000, size_q};
    s4 = {3'b000, size_q} << 2;
    size_ok  = (a5 > s4) && (a4 < s5);
    do_tok   = tok_i.valid && !tok_i.done;
    hit      = do_tok && !tok_i.sweep && valid_q && in_win && (wide || size_ok);
    age_new  = tok_i.now_ms - renewed_q;
    age_seen = tok_i.now_ms - seen_q;

    valid_d = valid_q; new_d = new_q; id_d = id_q; x_d = x_q; y_d = y_q;
    size_d = size_q; seen_d = seen_q; renewed_d = renewed_q;
    tok_d = tok_i;

    if (do_tok && tok_i.sweep && valid_q) begin
      if (age_new > {{(TimeW-PeriodW){1'b0}}, cfg_i.new_period_ms}) new_d = 1'b0;
      if (!(age_seen < {{(TimeW-PeriodW){1'b0}}, cfg_i.lost_timeout_ms})) begin
        valid_d = 1'b0;
        tok_d.removed = tok_i.removed + 1'b1;
      end
    end
    if (hit) begin
      x_d = tok_i.pos_x; y_d = tok_i.pos_y; seen_d = tok_i.now_ms;
      if (wide) begin
        size_d = tok_i.area;
        if (!new_q) begin
          new_d = 1'b1; renewed_d = tok_i.now_ms;
        end
      end
      tok_d.done = 1'b1; tok_d.matched = 1'b1; tok_d.id = id_q;
    end
    // The allocating transfer has left the chain, so its fields come from the tail.
    if (alloc_i) begin
      valid_d = 1'b1; new_d = 1'b1; id_d = alloc_id_i;
      x_d = alloc_tok_i.pos_x; y_d = alloc_tok_i.pos_y; size_d = alloc_tok_i.box_area;
      seen_d = alloc_tok_i.now_ms; renewed_d = alloc_tok_i.now_ms;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_q <= new_d; id_q <= id_d; x_q <= x_d; y_q <= y_d;
    size_q <= size_d; seen_q <= seen_d; renewed_q <= renewed_d;
  end

  assign tok_o   = tok_q;
  assign valid_o = valid_q;

endmodule

@@ src/gated_object_track_table_top.sv @@
// Channel  Dir  Fields (lowest bit up)
// s_axis   in   tuser: kind; tdata: pos_x, pos_y, area, box_area, now_ms, renew
// m_axis   out  tdata: status, object_id, removed_count
// cfg      in   cfg_we_i, cfg_idx_i, cfg_data_i
// A transfer passes one cell of the chain per cycle; its result is registered from the
// chain's tail, together with any slot allocation.
// The next item is taken only once the last one has left the chain and the result
// register is empty or being taken, so the block holds one item at a time.
// Reset empties the table and the id counter; no clearing pass.
// A stalled result holds the block; no item is lost.
module gated_object_track_table_top import gott_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [0:0]   s_axis_tuser_i,   // kind
  input  logic [103:0] s_axis_tdata_i,   // pos_x, pos_y, area, box_area, now_ms, renew
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [31:0]  m_axis_tdata_o,   // status, object_id, removed_count
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i
);

  gott_cfg_t cfg_q;
  gott_tok_t head;
  gott_tok_t chain [TableDepth+1];
  logic [TableDepth-1:0] vld, alloc;
  logic [IdW-1:0] next_id_q, new_id;
  logic busy_q, out_v_q;
  logic [31:0] out_q, res_d;
  logic [SlotW-1:0] free_slot;
  logic any_free, create;
  gott_tok_t tail;

  assign s_axis_tready_o = !busy_q && (!out_v_q || m_axis_tready_i);

  always_comb begin
    head = '0;
    head.valid    = s_axis_tvalid_i && s_axis_tready_o;
    head.sweep    = s_axis_tuser_i[0];
    head.pos_x    = s_axis_tdata_i[11:0];
    head.pos_y    = s_axis_tdata_i[23:12];
    head.area     = s_axis_tdata_i[43:24];
    head.box_area = s_axis_tdata_i[63:44];
    head.now_ms   = s_axis_tdata_i[95:64];
    head.renew    = s_axis_tdata_i[96];
  end

  assign chain[0] = head;
  assign new_id   = next_id_q + 1'b1;

  for (genvar k = 0; k < TableDepth; k++) begin : g_cell
    gott_cell u_cell (
      .clk_i, .rst_ni, .cfg_i(cfg_q), .alloc_i(alloc[k]),
      .alloc_id_i(new_id), .alloc_tok_i(tail), .tok_i(chain[k]),
      .tok_o(chain[k+1]), .valid_o(vld[k])
    );
  end

  always_comb begin
    free_slot = '0;
    any_free  = 1'b0;
    for (int k = TableDepth - 1; k >= 0; k--) begin
      if (!vld[k]) begin
        any_free = 1'b1; free_slot = SlotW'(k);
      end
    end
  end

  assign tail = chain[TableDepth];

  always_comb begin
    res_d  = '0;
    create = 1'b0;
    if (tail.sweep) begin
      res_d[1:0]   = StSweep;
      res_d[26:18] = RemW'(tail.removed);
    end else if (tail.matched) begin
      res_d[1:0]  = StMatched;
      res_d[17:2] = tail.id;
    end else if (any_free) begin
      res_d[1:0]  = StCreated;
      res_d[17:2] = new_id;
      create      = 1'b1;
    end else begin
      res_d[1:0] = StFull;
    end
  end

  always_comb begin
    alloc = '0;
    if (tail.valid && create)
      alloc[free_slot] = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q     <= '{gate_radius: 8'd20, lost_timeout_ms: 16'd1000, new_period_ms: 16'd1000};
      next_id_q <= '0;
      busy_q    <= 1'b0;
      out_v_q   <= 1'b0;
      out_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegGate:    cfg_q.gate_radius     <= cfg_data_i[GateW-1:0];
          RegTimeout: cfg_q.lost_timeout_ms <= cfg_data_i;
          RegPeriod:  cfg_q.new_period_ms   <= cfg_data_i;
          default: ;
        endcase
      end
      if (tail.valid) begin
        busy_q  <= 1'b0;
        out_v_q <= 1'b1;
        out_q   <= res_d;
        if (create) next_id_q <= new_id;
      end else begin
        if (head.valid) busy_q <= 1'b1;
        if (m_axis_tready_i) out_v_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o));
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy_q |-> !s_axis_tready_o);
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(alloc));
  assert property (@(posedge clk_i) disable iff (!rst_ni) tail.valid |-> busy_q && !out_v_q);

endmodule
